// File: rtl/core/pgc_pkg.sv
package pgc_pkg;

  // command codes of an input word
  localparam logic CMD_MOTION = 1'b0;
  localparam logic CMD_WRITE  = 1'b1;

  // configuration register indexes and reset values
  localparam int unsigned REG_OUT_LIMIT   = 0;
  localparam logic [6:0]  OUT_LIMIT_RESET = 7'd127;

  // digit-by-digit root starts at this bit
  localparam logic [15:0] ROOT_BIT_START = 16'h4000;
  // q8.8 gain: eight fraction bits
  localparam int unsigned FRAC_BITS      = 8;
  localparam int unsigned ACC_W          = 25;
  localparam int unsigned QUOT_W         = ACC_W - FRAC_BITS;
  localparam int unsigned GAIN_W         = 16;

  typedef enum logic [2:0] {
    S_IDLE,
    S_ROOT,
    S_READ,
    S_LOAD,
    S_MUL,
    S_DONE,
    S_ZERO
  } state_e;

  typedef struct packed {
    logic load;
    logic step;
    logic finish;
    logic clear;
  } scale_ctrl_t;

endpackage

// File: rtl/core/pointer_gain_curve_unit.sv
// channel  dir  handshake                     payload
// in       in   in_valid_i / in_ready_o       cmd_i dx_i dy_i table_index_i table_gain_i
// out      out  out_valid_o / out_ready_i     out_dx_o out_dy_o
// cfg      in   psel penable pwrite pready    paddr pwdata prdata (out_limit at 0)
//
// a motion word passes from accept to result through 8 squaring and 8 root
// digits in the root unit, one table read, one load and 16 shift-add steps of
// the gain multiply, then a step to round, clamp and register once the slot is free
// a table write or a zero motion word gives its zero result once the slot is free
// one word is in work at a time; the next is taken while the result waits
// reset clears the carries, the handshake state and out_limit (to 127)
module pointer_gain_curve_unit #(
  parameter int unsigned TABLE_DEPTH = 128
) (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              in_valid_i,
  output logic              in_ready_o,
  input  logic              cmd_i,
  input  logic signed [7:0] dx_i,
  input  logic signed [7:0] dy_i,
  input  logic [6:0]        table_index_i,
  input  logic [15:0]       table_gain_i,
  output logic              out_valid_o,
  input  logic              out_ready_i,
  output logic signed [7:0] out_dx_o,
  output logic signed [7:0] out_dy_o,
  input  logic              psel,
  input  logic              penable,
  input  logic              pwrite,
  input  logic [2:0]        paddr,
  input  logic [31:0]       pwdata,
  output logic [31:0]       prdata,
  output logic              pready
);
  import pgc_pkg::*;

  localparam int unsigned IDX_W = $clog2(TABLE_DEPTH);

  state_e             state_q, state_d;
  logic [3:0]         mul_cnt_q, mul_cnt_d;
  logic [6:0]         out_limit_q;
  logic signed [7:0]  dx_q, dy_q;
  logic               out_valid_q, out_valid_d;
  logic signed [7:0]  out_dx_q, out_dx_d, out_dy_q, out_dy_d;
  logic               accept;
  logic               slot_free;
  logic               zero_motion;
  logic [7:0]         mag_x, mag_y;
  logic               root_start, root_done;
  logic [7:0]         root;
  logic [IDX_W-1:0]   rd_idx, ram_addr;
  logic               ram_we;
  logic [GAIN_W-1:0]  gain;
  scale_ctrl_t        sctrl;
  logic signed [7:0]  qx, qy;
  logic               cfg_write;

  assign accept      = in_valid_i && in_ready_o;
  assign in_ready_o  = (state_q == S_IDLE);
  assign slot_free   = !out_valid_q || out_ready_i;
  assign zero_motion = (dx_i == 8'sd0) && (dy_i == 8'sd0);

  assign mag_x = dx_i[7] ? 8'(-dx_i) : 8'(dx_i);
  assign mag_y = dy_i[7] ? 8'(-dy_i) : 8'(dy_i);

  // configuration port
  assign pready    = 1'b1;
  assign cfg_write = psel && penable && pwrite && pready
                     && (32'(paddr[2]) == REG_OUT_LIMIT);
  assign prdata    = (32'(paddr[2]) == REG_OUT_LIMIT) ? {25'd0, out_limit_q} : 32'd0;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_limit_q <= OUT_LIMIT_RESET;
    end else if (cfg_write) begin
      out_limit_q <= pwdata[6:0];
    end
  end

  // gain table
  assign rd_idx   = (32'(root) >= TABLE_DEPTH) ? IDX_W'(TABLE_DEPTH - 1) : IDX_W'(root);
  assign ram_addr = (state_q == S_IDLE) ? IDX_W'(table_index_i) : rd_idx;
  assign ram_we   = accept && (cmd_i == CMD_WRITE) && (32'(table_index_i) < TABLE_DEPTH);

  pgc_ram #(
    .WIDTH (GAIN_W),
    .DEPTH (TABLE_DEPTH)
  ) u_table (
    .clk_i   (clk_i),
    .we_i    (ram_we),
    .addr_i  (ram_addr),
    .wdata_i (table_gain_i),
    .rdata_o (gain)
  );

  pgc_sqrt u_sqrt (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .start_i (root_start),
    .mag_x_i (mag_x),
    .mag_y_i (mag_y),
    .done_o  (root_done),
    .root_o  (root)
  );

  pgc_scale u_scale_x (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .ctrl_i (sctrl),
    .d_i    (dx_q),
    .gain_i (gain),
    .lim_i  (out_limit_q),
    .q_o    (qx)
  );

  pgc_scale u_scale_y (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .ctrl_i (sctrl),
    .d_i    (dy_q),
    .gain_i (gain),
    .lim_i  (out_limit_q),
    .q_o    (qy)
  );

  always_comb begin
    state_d     = state_q;
    mul_cnt_d   = mul_cnt_q;
    out_valid_d = out_valid_q && !out_ready_i;
    out_dx_d    = out_dx_q;
    out_dy_d    = out_dy_q;
    root_start  = 1'b0;
    sctrl       = '0;
    case (state_q)
      S_IDLE: begin
        if (accept) begin
          if (cmd_i == CMD_WRITE) begin
            state_d = S_ZERO;
          end else if (zero_motion) begin
            sctrl.clear = 1'b1;
            state_d     = S_ZERO;
          end else begin
            root_start = 1'b1;
            state_d    = S_ROOT;
          end
        end
      end
      S_ROOT: begin
        if (root_done) begin
          state_d = S_READ;
        end
      end
      S_READ: begin
        state_d = S_LOAD;
      end
      S_LOAD: begin
        sctrl.load = 1'b1;
        mul_cnt_d  = '0;
        state_d    = S_MUL;
      end
      S_MUL: begin
        sctrl.step = 1'b1;
        mul_cnt_d  = mul_cnt_q + 4'd1;
        if (mul_cnt_q == 4'd15) begin
          state_d = S_DONE;
        end
      end
      S_DONE: begin
        if (slot_free) begin
          sctrl.finish = 1'b1;
          out_valid_d  = 1'b1;
          out_dx_d     = qx;
          out_dy_d     = qy;
          state_d      = S_IDLE;
        end
      end
      S_ZERO: begin
        if (slot_free) begin
          out_valid_d = 1'b1;
          out_dx_d    = 8'sd0;
          out_dy_d    = 8'sd0;
          state_d     = S_IDLE;
        end
      end
      default: begin
        state_d = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_IDLE;
      mul_cnt_q   <= '0;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      mul_cnt_q   <= mul_cnt_d;
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    out_dx_q <= out_dx_d;
    out_dy_q <= out_dy_d;
    if (accept) begin
      dx_q <= dx_i;
      dy_q <= dy_i;
    end
  end

  assign out_valid_o = out_valid_q;
  assign out_dx_o    = out_dx_q;
  assign out_dy_o    = out_dy_q;

endmodule

// File: rtl/core/pgc_ram.sv
module pgc_ram #(
  parameter int unsigned WIDTH = 16,
  parameter int unsigned DEPTH = 128
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(DEPTH)-1:0] addr_i,
  input  logic [WIDTH-1:0]         wdata_i,
  output logic [WIDTH-1:0]         rdata_o
);

  logic [WIDTH-1:0] mem [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem[addr_i] <= wdata_i;
    end
    rdata_q <= mem[addr_i];
  end

  assign rdata_o = rdata_q;

endmodule

// File: rtl/core/pgc_sqrt.sv
module pgc_sqrt (
  input  logic       clk_i,
  input  logic       rst_ni,
  input  logic       start_i,
  input  logic [7:0] mag_x_i,
  input  logic [7:0] mag_y_i,
  output logic       done_o,
  output logic [7:0] root_o
);
  import pgc_pkg::*;

  logic        busy_q, busy_d;
  logic [3:0]  cnt_q, cnt_d;
  logic [15:0] n_q, n_d;
  logic [15:0] res_q, res_d;
  logic [15:0] bit_q, bit_d;
  logic [15:0] mx_q, mx_d, my_q, my_d;
  logic [7:0]  bx_q, bx_d, by_q, by_d;
  logic [15:0] trial;
  logic        done;

  assign trial = res_q + bit_q;

  always_comb begin
    busy_d = busy_q;
    cnt_d  = cnt_q;
    n_d    = n_q;
    res_d  = res_q;
    bit_d  = bit_q;
    mx_d   = mx_q;
    my_d   = my_q;
    bx_d   = bx_q;
    by_d   = by_q;
    done   = 1'b0;
    if (start_i) begin
      busy_d = 1'b1;
      cnt_d  = '0;
      n_d    = '0;
      res_d  = '0;
      bit_d  = ROOT_BIT_START;
      mx_d   = {8'd0, mag_x_i};
      my_d   = {8'd0, mag_y_i};
      bx_d   = mag_x_i;
      by_d   = mag_y_i;
    end else if (busy_q) begin
      cnt_d = cnt_q + 4'd1;
      if (!cnt_q[3]) begin
        // squaring phase: one multiplier bit of each axis per cycle
        n_d  = n_q + (bx_q[0] ? mx_q : 16'd0) + (by_q[0] ? my_q : 16'd0);
        mx_d = mx_q << 1;
        my_d = my_q << 1;
        bx_d = bx_q >> 1;
        by_d = by_q >> 1;
      end else begin
        // root phase: one result digit per cycle
        if (n_q >= trial) begin
          n_d   = n_q - trial;
          res_d = (res_q >> 1) + bit_q;
        end else begin
          res_d = res_q >> 1;
        end
        bit_d = bit_q >> 2;
        if (cnt_q == 4'd15) begin
          busy_d = 1'b0;
          done   = 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      cnt_q  <= '0;
    end else begin
      busy_q <= busy_d;
      cnt_q  <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    n_q   <= n_d;
    res_q <= res_d;
    bit_q <= bit_d;
    mx_q  <= mx_d;
    my_q  <= my_d;
    bx_q  <= bx_d;
    by_q  <= by_d;
  end

  assign done_o = done;
  assign root_o = res_q[7:0];

endmodule

// File: rtl/core/pgc_scale.sv
module pgc_scale (
  input  logic                      clk_i,
  input  logic                      rst_ni,
  input  pgc_pkg::scale_ctrl_t      ctrl_i,
  input  logic signed [7:0]         d_i,
  input  logic [pgc_pkg::GAIN_W-1:0] gain_i,
  input  logic [6:0]                lim_i,
  output logic signed [7:0]         q_o
);
  import pgc_pkg::*;

  logic signed [ACC_W-1:0]  acc_q, acc_d;
  logic signed [ACC_W-1:0]  md_q, md_d;
  logic [GAIN_W-1:0]        g_q, g_d;
  logic signed [8:0]        carry_q, carry_d;
  logic signed [QUOT_W-1:0] quot;
  logic signed [QUOT_W-1:0] lim_pos;
  logic signed [QUOT_W-1:0] lim_neg;
  logic signed [QUOT_W-1:0] clamped;
  logic                     round_up;

  // truncation toward zero: negative sums with a fraction round up
  assign round_up = acc_q[ACC_W-1] && (acc_q[FRAC_BITS-1:0] != '0);
  assign quot     = QUOT_W'(acc_q >>> FRAC_BITS) + QUOT_W'(round_up);
  assign lim_pos  = QUOT_W'({1'b0, lim_i});
  assign lim_neg  = -lim_pos;

  always_comb begin
    if (quot > lim_pos) begin
      clamped = lim_pos;
    end else if (quot < lim_neg) begin
      clamped = lim_neg;
    end else begin
      clamped = quot;
    end
  end

  assign q_o = clamped[7:0];

  always_comb begin
    acc_d   = acc_q;
    md_d    = md_q;
    g_d     = g_q;
    carry_d = carry_q;
    if (ctrl_i.load) begin
      acc_d = ACC_W'(carry_q);
      md_d  = ACC_W'(d_i);
      g_d   = gain_i;
    end else if (ctrl_i.step) begin
      // shift-add, one gain bit per cycle
      if (g_q[0]) begin
        acc_d = acc_q + md_q;
      end
      md_d = md_q <<< 1;
      g_d  = g_q >> 1;
    end
    if (ctrl_i.clear) begin
      carry_d = '0;
    end else if (ctrl_i.finish) begin
      carry_d = {round_up, acc_q[FRAC_BITS-1:0]};
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      carry_q <= '0;
    end else begin
      carry_q <= carry_d;
    end
  end

  always_ff @(posedge clk_i) begin
    acc_q <= acc_d;
    md_q  <= md_d;
    g_q   <= g_d;
  end

endmodule
